// ===== design/double_ended_queue_macros.svh =====
// Assertion macros shared by the double-ended queue modules.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dq_pkg;

  // Default number of ring entries.
  localparam int DQ_DEPTH_DEFAULT = 16;

  // Word width of the stored entries.
  localparam int DQ_WORD_W = 32;

  // Request kinds, coded as on the input selector.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_ALL   = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    op_t                         op;
    logic signed [DQ_WORD_W-1:0] value;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_RUN
  } bstate_t;

endpackage

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue: front end, command queue and back end.
// Depends on dq_pkg, dq_front and dq_back.
//
//   Channel  Direction  Handshake             tdata       tuser    tlast
//   in_      slave      in_tvalid/in_tready   value       mode     -
//   out_     master     out_tvalid/out_tready value_res   status   last
//
// A word is registered in the command queue before it reaches the back end.
// A push writes the ring store directly; a pop waits on its registered read
// port; a read-all returns a word per entry, holding further commands meanwhile.
// Reset is synchronous, active low, and empties the queue. A stalled output holds
// the back end, while the front end accepts words until its command queue is full.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [dq_pkg::DQ_WORD_W-1:0] in_tdata,   // value
  input  logic [2:0]                          in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [dq_pkg::DQ_WORD_W-1:0] out_tdata,  // value_res
  output logic [1:0]                          out_tuser,  // status
  output logic                                out_tlast
);
  import dq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and classify requests.
  dq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Carry out requests on the ring store.
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/dq_front.sv =====
// Front end of the double-ended queue: accepts input words, drops undefined
// request kinds and buffers the rest in a two-entry command queue. Uses dq_pkg.
`timescale 1ns / 1ps

module dq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic signed [dq_pkg::DQ_WORD_W-1:0] in_tdata,  // value
  input  logic [2:0]                     in_tuser,  // mode
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output dq_pkg::cmd_t                   cmd
);
  import dq_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       legal;
  logic       push;
  logic       pop;

  // Only the five defined request kinds enter the queue.
  always_comb begin
    unique case (in_tuser) inside
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_BACK, OP_POP_FRONT, OP_READ_ALL: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && legal;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_t'(in_tuser), value: in_tdata};
    end
  end

endmodule

// ===== design/dq_back.sv =====
// Back end of the double-ended queue: ring store, pointers, sequencer and
// the output register. Uses dq_pkg and double_ended_queue_macros.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module dq_back #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  dq_pkg::cmd_t                        cmd,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [dq_pkg::DQ_WORD_W-1:0] out_tdata,  // value_res
  output logic [1:0]                          out_tuser,  // status
  output logic                                out_tlast
);
  import dq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] WRAP     = SW'(DEPTH);

  // Ring store with registered read port.
  logic signed [DQ_WORD_W-1:0] mem [DEPTH];
  logic signed [DQ_WORD_W-1:0] rd_data_r;
  logic                        wr_en, rd_en;
  logic [IW-1:0]               wr_addr, rd_addr;

  // Queue state and sequencer.
  bstate_t       state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  // Output register.
  logic                        out_valid_r;
  logic signed [DQ_WORD_W-1:0] out_value_r;
  status_t                     out_status_r;
  logic                        out_last_r;
  logic                        out_free;
  logic                        ld;
  logic signed [DQ_WORD_W-1:0] ld_value;
  status_t                     ld_status;
  logic                        ld_last;

  // Ring position arithmetic.
  logic          full, empty;
  logic [IW-1:0] front_dec, front_inc, rp_inc;
  logic [SW-1:0] sum_push, sum_pop;
  logic [IW-1:0] back_push, back_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign out_free = !out_valid_r || out_tready;

  // Neighbouring ring positions; sums stay below twice the depth.
  always_comb begin
    front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
    front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
    rp_inc    = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
    sum_push  = SW'(front_r) + SW'(count_r);
    sum_pop   = sum_push - 1'b1;
    back_push = (sum_push >= WRAP) ? IW'(sum_push - WRAP) : IW'(sum_push);
    back_pop  = (sum_pop >= WRAP) ? IW'(sum_pop - WRAP) : IW'(sum_pop);
  end

  // Sequencer: next state, store access and result loading.
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    rp_nxt    = rp_r;
    rem_nxt   = rem_r;
    cmd_ready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    ld        = 1'b0;
    ld_value  = '0;
    ld_status = ST_OK;
    ld_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = back_push;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = back_pop;
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                front_nxt = front_inc;
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                rp_nxt    = front_inc;
                rem_nxt   = count_r;
                state_nxt = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // The popped word arrives from the store's registered read port in the cycle after the read.
        if (out_free) begin
          ld        = 1'b1;
          ld_value  = rd_data_r;
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        // One stored entry per cycle while the output is free, front to back; the next read overlaps.
        if (out_free) begin
          ld       = 1'b1;
          ld_value = rd_data_r;
          ld_last  = (rem_r == CW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rem_nxt = rem_r - 1'b1;
            rd_en   = 1'b1;
            rd_addr = rp_r;
            rp_nxt  = rp_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rp_r <= rp_nxt;
    if (ld) begin
      out_value_r  <= ld_value;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  // Ring store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Checks on the queue state and the sequencer.
  `DQ_ASSERT_ALWAYS(a_count_bound, count_r <= FULL_CNT, "entry count above depth")
  `DQ_ASSERT_ALWAYS(a_front_bound, front_r <= LAST_IDX, "front index outside ring")
  `DQ_ASSERT_ALWAYS(a_run_rem, state_r != S_RUN || (rem_r != '0 && rem_r <= count_r), "bad run length")
  `DQ_ASSERT_NEXT(a_run_start, state_r == S_IDLE && state_nxt == S_RUN, rem_r == count_r, "run length differs from count")
  `DQ_ASSERT_NEXT(a_no_write_run, state_r == S_RUN, $stable(count_r) && $stable(front_r), "queue changed during read-out")

endmodule

// ===== dv/dq_checker.sv =====
// Checker for the double-ended queue: watches both streams, mirrors the ring
// and compares every result word with the predicted one. Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_checker #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic signed [dq_pkg::DQ_WORD_W-1:0] in_tdata,   // value
  input  logic [2:0]                          in_tuser,   // mode
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic signed [dq_pkg::DQ_WORD_W-1:0] out_tdata,  // value_res
  input  logic [1:0]                          out_tuser,  // status
  input  logic                                out_tlast,
  output int                                  fail_count,
  output int                                  words_pending
);

  import dq_pkg::*;

  localparam int REPORT_MAX = 10;

  // One predicted result word.
  typedef struct packed {
    logic signed [DQ_WORD_W-1:0] word;
    status_t                     status;
    logic                        last;
  } answer_t;

  // Mirror of the ring and its bookkeeping.
  logic signed [DQ_WORD_W-1:0] ring_words [DEPTH];
  int                          front_slot;
  int                          held;

  // Results owed by the block, oldest first.
  answer_t answers_due [$];

  initial begin
    fail_count    = 0;
    words_pending = 0;
    front_slot    = 0;
    held          = 0;
  end

  // Applies one accepted request to the mirror and queues the words it owes.
  task automatic predict_answers(input logic [2:0] mode,
                                 input logic signed [DQ_WORD_W-1:0] value);
    int slot;
    case (mode) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held == DEPTH) begin
          answers_due.push_back(answer_t'{'0, ST_FULL, 1'b1});
        end else begin
          if (mode == OP_PUSH_FRONT) begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            slot = front_slot;
          end else begin
            slot = (front_slot + held) % DEPTH;
          end
          ring_words[slot] = value;
          held++;
          answers_due.push_back(answer_t'{'0, ST_OK, 1'b1});
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (held == 0) begin
          answers_due.push_back(answer_t'{'0, ST_EMPTY, 1'b1});
        end else begin
          if (mode == OP_POP_BACK) begin
            slot = (front_slot + held - 1) % DEPTH;
          end else begin
            slot = front_slot;
            front_slot = (front_slot + 1) % DEPTH;
          end
          held--;
          answers_due.push_back(answer_t'{ring_words[slot], ST_OK, 1'b1});
        end
      end
      OP_READ_ALL: begin
        if (held == 0) begin
          answers_due.push_back(answer_t'{'0, ST_EMPTY, 1'b1});
        end else begin
          for (int i = 0; i < held; i++) begin
            answers_due.push_back(answer_t'{ring_words[(front_slot + i) % DEPTH], ST_OK,
                                             1'b1 & (i == held - 1)});
          end
        end
      end
      // Undefined modes are dropped by the block without a result.
      default: ;
    endcase
  endtask

  // Sample both channels on the rising edge, requests before results.
  always @(posedge clk) begin : watch
    answer_t due;
    if (!rst_n) begin
      front_slot = 0;
      held       = 0;
      answers_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_answers(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("[%0t] unexpected result word: value %0d status %0d last %0b",
                     $realtime, out_tdata, out_tuser, out_tlast);
          end
        end else begin
          due = answers_due.pop_front();
          if (out_tdata !== due.word || out_tuser !== due.status ||
              out_tlast !== due.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("[%0t] result mismatch: expected value %0d status %0d last %0b,",
                       $realtime, due.word, due.status, due.last);
              $display("          got value %0d status %0d last %0b",
                       out_tdata, out_tuser, out_tlast);
            end
          end
        end
      end
    end
    words_pending <= answers_due.size();
  end

endmodule

// ===== dv/double_ended_queue_tb.sv =====
// Testbench top for the double-ended queue: drives requests and back-pressure
// and gives the verdict. Depends on dq_pkg, double_ended_queue and dq_checker.
`timescale 1ns / 1ps

module double_ended_queue_tb;

  import dq_pkg::*;

  localparam int  DEPTH        = DQ_DEPTH_DEFAULT;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  PHASE_ITEMS  = 128;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic signed [DQ_WORD_W-1:0] in_tdata;
  logic [2:0]                  in_tuser;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic signed [DQ_WORD_W-1:0] out_tdata;
  logic [1:0]                  out_tuser;
  logic                        out_tlast;

  int fail_count;
  int words_pending;
  int in_gap_pct;
  int out_stall_pct;
  int cycles;

  double_ended_queue #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dq_checker #(.DEPTH(DEPTH)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly random words, with the signed extremes, zero and minus one mixed in.
  function automatic logic signed [DQ_WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(DQ_WORD_W-1){1'b0}}};
      1:       return {1'b0, {(DQ_WORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request word, after a random gap, and waits for its acceptance.
  task automatic send_word(input logic [2:0] mode, input logic signed [DQ_WORD_W-1:0] value);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random requests; the fill bias drifts so the queue swings between full and empty.
  task automatic run_phase(input int gap_pct, input int stall_pct, input int n_items);
    int         sent;
    int         roll;
    int         fill_bias;
    logic [2:0] mode;
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    sent          = 0;
    fill_bias     = 70;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) fill_bias = $urandom_range(0, 1) ? 85 : 20;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        mode = 3'($urandom_range(5, 7));
      end else if (roll < 10) begin
        mode = OP_READ_ALL;
      end else if ($urandom_range(0, 99) < fill_bias) begin
        mode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        mode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_word(mode, pick_word());
      if (mode <= 3'(OP_READ_ALL)) sent++;
    end
  endtask

  initial begin
    cycles        = 0;
    in_gap_pct    = 16;
    out_stall_pct = 62;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, popping the only entry from either end.
    send_word(OP_POP_BACK, pick_word());
    send_word(OP_POP_FRONT, pick_word());
    send_word(OP_READ_ALL, pick_word());
    send_word(OP_PUSH_FRONT, {1'b1, {(DQ_WORD_W-1){1'b0}}});
    send_word(OP_POP_BACK, '0);
    send_word(OP_PUSH_BACK, {1'b0, {(DQ_WORD_W-1){1'b1}}});
    send_word(OP_POP_FRONT, '1);
    // Undefined modes are ignored by the block.
    send_word(3'd5, '1);
    send_word(3'd6, '0);
    send_word(3'd7, '1);
    // Fill from both ends, then push into a full queue and read it all out.
    for (int i = 0; i < DEPTH; i++) begin
      send_word((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, (i < 4) ? pick_word() : $urandom);
    end
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_PUSH_BACK, '1);
    send_word(OP_READ_ALL, '0);

    // Random traffic under three idling profiles.
    run_phase(16, 62, PHASE_ITEMS);
    run_phase(62, 16, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then allow the pipeline to settle.
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
